### rtl/core/pdf_pkg.sv
// Shared constants and types for the packet duplicate filter.
package pdf_pkg;

  localparam int HASH_W = 32;
  localparam int TIME_W = 32;
  localparam int WIN_W = 16;

  localparam int ENTRIES_DEFAULT = 16;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

  // Per-cycle commands from the sequencer to the ring.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } pdf_ctrl_t;

endpackage

### rtl/core/pdf_ring.sv
// Hash/time ring storage with the shared match compare unit.
module pdf_ring
  import pdf_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT,
  localparam int ADDR_W = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  pdf_ctrl_t         ctrl,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [HASH_W-1:0] key_hash,
  input  logic [TIME_W-1:0] key_time,
  input  logic [WIN_W-1:0]  window,
  output logic              hit
);

  logic [HASH_W-1:0] hash_mem [ENTRIES];
  logic [TIME_W-1:0] time_mem [ENTRIES];
  logic [ENTRIES-1:0] entry_vld;

  logic [HASH_W-1:0] rd_hash;
  logic [TIME_W-1:0] rd_time;
  logic              rd_vld;
  logic              rd_pend;

  logic [HASH_W-1:0] eff_hash;
  logic [TIME_W-1:0] eff_time;
  logic [TIME_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      hash_mem[wr_addr] <= key_hash;
      time_mem[wr_addr] <= key_time;
    end
    if (ctrl.rd_en) begin
      rd_hash <= hash_mem[rd_addr];
      rd_time <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
      rd_pend   <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        entry_vld[wr_addr] <= 1'b1;
      end
      rd_pend <= ctrl.rd_en;
      if (ctrl.rd_en) begin
        rd_vld <= entry_vld[rd_addr];
      end
    end
  end

  // Slots never written since reset read as zero hash, zero time.
  assign eff_hash = rd_vld ? rd_hash : '0;
  assign eff_time = rd_vld ? rd_time : '0;
  // Window end wraps mod 2^32.
  assign limit = eff_time + TIME_W'(window);
  assign hit = rd_pend && (eff_hash == key_hash) && (key_time < limit);

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.rd_en && ctrl.wr_en))
    else $error("ring read and write in the same cycle");

  a_pend_follows_rd: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |=> rd_pend)
    else $error("read data not flagged after read");

  a_write_sets_vld: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |=> entry_vld[$past(wr_addr)])
    else $error("written slot not marked valid");
`endif

endmodule

### rtl/core/packet_duplicate_filter.sv
// Packet duplicate filter: top level with scan sequencer and config register.
//
// Each input transfer carries a packet hash and the current millisecond time.
// The block scans a ring of ENTRIES stored hashes one slot per cycle through
// a single read port and one add/compare unit, then reports the verdict and,
// if the packet is no duplicate, records it at the ring's insert slot. The
// ring read is registered, so S_LAST takes the compare of the last slot read
// and S_WRITE then records the packet and issues the result; in_ready is high
// only between items, so a new item is taken only once the last is through.
// With the output register still full, the result waits in S_HOLD. A finished
// result sits in the output register, and a new item is taken while it waits.
// The user is to write window_ms through the cfg port only while the block is
// idle; the block itself does not enforce this. The ring resets to all-zero
// entries through per-slot valid bits, so no clearing pass is needed.
module packet_duplicate_filter
  import pdf_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [HASH_W-1:0] packet_hash,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_duplicate,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [WIN_W-1:0]  window_ms
);

  localparam int ADDR_W = $clog2(ENTRIES);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LAST  = 5'b00100,
    S_WRITE = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t            state;
  logic [WIN_W-1:0]  window;
  logic [HASH_W-1:0] key_hash;
  logic [TIME_W-1:0] key_time;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] insert_slot;
  logic              dup;

  pdf_ctrl_t ctrl;
  logic      hit;
  logic      out_free;
  logic      issue;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  // result moves into the output register this cycle
  assign issue     = ((state == S_WRITE) || (state == S_HOLD)) && out_free;

  always_comb begin
    ctrl.rd_en = (state == S_SCAN);
    ctrl.wr_en = (state == S_WRITE) && !dup;
  end

  pdf_ring #(
    .ENTRIES(ENTRIES)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .rd_addr  (scan_addr),
    .wr_addr  (insert_slot),
    .key_hash (key_hash),
    .key_time (key_time),
    .window   (window),
    .hit      (hit)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_hash <= packet_hash;
      key_time <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      window       <= WINDOW_RESET;
      scan_addr    <= '0;
      insert_slot  <= '0;
      dup          <= 1'b0;
      out_valid    <= 1'b0;
      is_duplicate <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window <= window_ms;
      end
      if (out_valid && out_ready && !issue) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan_addr <= '0;
            dup       <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // hit reflects the slot read in the previous cycle
          dup <= dup | hit;
          if (scan_addr == LAST_SLOT) begin
            state <= S_LAST;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_LAST: begin
          dup   <= dup | hit;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (!dup) begin
            insert_slot <= (insert_slot == LAST_SLOT) ? '0 : insert_slot + 1'b1;
          end
          if (out_free) begin
            out_valid    <= 1'b1;
            is_duplicate <= dup;
            state        <= S_IDLE;
          end else begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            is_duplicate <= dup;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN) && (scan_addr == '0))
    else $error("accepted item did not start a scan");

  a_hold_means_busy_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |-> out_valid)
    else $error("holding a result while the output register is free");

  a_dup_not_recorded: assert property (@(posedge clk) disable iff (rst)
    ((state == S_WRITE) && dup) |=> $stable(insert_slot))
    else $error("duplicate advanced the insert slot");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    insert_slot <= LAST_SLOT)
    else $error("insert slot beyond ring");
`endif

endmodule

### tb/packet_duplicate_filter_test.sv
// Self-checking testbench for packet_duplicate_filter: directed and random traffic.
`timescale 1ns / 1ps

module packet_duplicate_filter_test
  import pdf_pkg::*;
();

  localparam int RING_DEPTH = ENTRIES_DEFAULT;

  // Tracks the ring of recently recorded hashes and queues one verdict per transfer.
  class dup_verdict_board;
    logic [HASH_W-1:0] ring_hash [RING_DEPTH];
    logic [TIME_W-1:0] ring_time [RING_DEPTH];
    int                ring_slot;
    logic [WIN_W-1:0]  window;
    bit                expected_verdicts [$];
    int                errors;

    function new();
      foreach (ring_hash[k]) begin
        ring_hash[k] = '0;
        ring_time[k] = '0;
      end
      ring_slot = 0;
      window = WINDOW_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_window(logic [WIN_W-1:0] w);
      window = w;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // A hit in any slot whose stored time plus window (mod 2^32) is still ahead of now.
    function bit seen_recently(logic [HASH_W-1:0] hash, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] limit;
      for (int k = 0; k < RING_DEPTH; k++) begin
        limit = ring_time[k] + TIME_W'(window);
        if (ring_hash[k] == hash && now < limit) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_packet(logic [HASH_W-1:0] hash, logic [TIME_W-1:0] now);
      bit dup;
      dup = seen_recently(hash, now);
      if (!dup) begin
        ring_hash[ring_slot] = hash;
        ring_time[ring_slot] = now;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
      end
      expected_verdicts.push_back(dup);
    endfunction

    task check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("is_duplicate=%b with no packet outstanding", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want)
          report($sformatf("is_duplicate=%b, expected %b", got, want));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [HASH_W-1:0] packet_hash = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              is_duplicate;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [WIN_W-1:0]  window_ms = '0;

  dup_verdict_board  board = new();
  bit                steady = 1'b0;
  int unsigned       stall_left = 0;
  logic [TIME_W-1:0] clock_ms;
  logic [HASH_W-1:0] recent_hashes [$];

  packet_duplicate_filter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .packet_hash  (packet_hash),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_duplicate (is_duplicate),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_ms    (window_ms)
  );

  always #5 clk = ~clk;

  // Sink back-pressure: mostly short stalls, occasionally long ones.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_verdict(is_duplicate);
  end

  // Holds valid until the transfer; the caller decides whether valid drops afterwards.
  task send_packet(logic [HASH_W-1:0] hash, logic [TIME_W-1:0] now);
    in_valid <= 1'b1;
    packet_hash <= hash;
    now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_packet(hash, now);
  endtask

  task sender_gap();
    int n;
    n = 0;
    if (!steady) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(10, 40);
        1, 2, 3, 4, 5: n = $urandom_range(1, 3);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task wait_all_verdicts();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task write_window(logic [WIN_W-1:0] w);
    wait_all_verdicts();
    cfg_valid <= 1'b1;
    window_ms <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_window(w);
    cfg_valid <= 1'b0;
  endtask

  task directed(logic [HASH_W-1:0] hash, logic [TIME_W-1:0] now);
    send_packet(hash, now);
    sender_gap();
  endtask

  // Mostly recent hashes with small time steps so matches land inside the window.
  task random_packet(int unsigned win);
    logic [HASH_W-1:0] hash;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 60 && recent_hashes.size() != 0)
      hash = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
    else if (pick < 68)
      hash = '0;
    else
      hash = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      clock_ms = clock_ms + $urandom_range(0, win / 6 + 2);
    else if (pick < 92)
      clock_ms = clock_ms + $urandom_range(0, 2 * win + 20);
    else
      clock_ms = $urandom;
    send_packet(hash, clock_ms);
    recent_hashes.push_back(hash);
    if (recent_hashes.size() > 24) void'(recent_hashes.pop_front());
    sender_gap();
  endtask

  initial begin
    logic [WIN_W-1:0] phase_window [6];
    phase_window[0] = 16'd1;
    phase_window[1] = 16'hFFFF;
    phase_window[2] = 16'd0;
    phase_window[3] = WIN_W'($urandom);
    phase_window[4] = WINDOW_RESET;
    phase_window[5] = WIN_W'($urandom_range(50, 3000));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window: zeroed slots match a zero hash early on, then the wrap point.
    directed(32'h0, 32'd0);
    directed(32'h0, 32'd999);
    directed(32'h0, 32'd1000);
    directed(32'h0, 32'd1999);
    directed(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    directed(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    directed(32'hFFFF_FFFF, 32'd5);
    directed(32'hA5A5_A5A5, 32'h7FFF_FFFF);
    directed(32'hA5A5_A5A5, 32'h8000_03E6);
    directed(32'hA5A5_A5A5, 32'h8000_03E7);
    directed(32'hA5A5_A5A5, 32'h8000_05DB);
    directed(32'h5A5A_5A5A, 32'h8000_05DB);

    // Zero window: only an entry stored with a later time than now still matches.
    write_window(16'd0);
    directed(32'h0, 32'd0);
    directed(32'h0, 32'd0);
    directed(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Widest window, straddling the time wrap.
    write_window(16'hFFFF);
    directed(32'h1234_5678, 32'hFFFF_0000);
    directed(32'h1234_5678, 32'hFFFF_FFFE);
    directed(32'h1234_5678, 32'hFFFF_FFFF);
    directed(32'h1234_5678, 32'h0000_0010);
    directed(32'h1234_5678, 32'h0000_FFFE);
    directed(32'hFFFF_FFFF, 32'h0000_0000);
    directed(32'h0, 32'h0001_0000);

    for (int p = 0; p < 6; p++) begin
      write_window(phase_window[p]);
      steady = (p == 4);
      clock_ms = (p == 3) ? 32'hFFFF_F000 - $urandom_range(0, 4000) : $urandom;
      for (int i = 0; i < 65; i++) begin
        if (p == 1 && i == 30) wait_all_verdicts();
        random_packet(phase_window[p]);
      end
    end
    steady = 1'b0;

    wait_all_verdicts();
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
rtl/core/pdf_pkg.sv
rtl/core/pdf_ring.sv
rtl/core/packet_duplicate_filter.sv
tb/packet_duplicate_filter_test.sv
